/* rtl/gsag_pkg.sv */
// Package with the shared types and codes of the gather/scatter address generator.
package gsag_pkg;

    localparam int ENTRY_BITS = 32;
    localparam int CFG_BITS   = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int ADDR_BITS  = 48;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_MAIN    = 3'd1,
        OP_GATHER  = 3'd2,
        OP_SCATTER = 3'd3,
        OP_STEP    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KM_GATHER       = 3'd0,
        KM_SCATTER      = 3'd1,
        KM_GS           = 3'd2,
        KM_MULTIGATHER  = 3'd3,
        KM_MULTISCATTER = 3'd4
    } kmode_t;

    typedef enum logic [2:0] {
        CFG_KERNEL_MODE   = 3'd0,
        CFG_SOURCE_BASE   = 3'd1,
        CFG_TARGET_BASE   = 3'd2,
        CFG_GATHER_DELTA  = 3'd3,
        CFG_SCATTER_DELTA = 3'd4,
        CFG_WRAP_COUNT    = 3'd5,
        CFG_REPEAT_COUNT  = 3'd6,
        CFG_ACCESS_BYTES  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic                 is_write;
        logic [6:0]           size_bytes;
        logic                 last;
        logic                 run_done;
        logic                 index_error;
    } out_item_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ1,
        BK_READ2,
        BK_MUL,
        BK_EMIT_RD,
        BK_EMIT_WR
    } bk_state_t;

endpackage

/* rtl/gather_scatter_address_generator.sv */
// Top level of the gather/scatter address generator.
// A step command is picked up by the idle back end, which reads the tables, waits while the
// remainder unit for the wrap offset finishes, passes a multiply state, then emits the read
// beat and the write beat on consecutive cycles; a step with an empty pattern, an invalid kernel
// mode or a finished run emits nothing. Appends and clears wait until all queued steps are done.
// Up to two steps queue while one is at work. Results cannot be stalled.
module gather_scatter_address_generator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  gsag_pkg::in_item_t    item,
    output logic                  result_valid,
    output gsag_pkg::out_item_t   result,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [47:0]           cfg_data
);
    import gsag_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = AW + 1;

    logic [2:0]  kernel_mode_reg;
    logic [47:0] source_base_reg, target_base_reg;
    logic [31:0] gather_delta_reg, scatter_delta_reg, wrap_count_reg, repeat_count_reg;
    logic [6:0]  access_bytes_reg;

    logic          step_valid, pop, back_idle, clear_run;
    logic          we_main, we_gather, we_scatter;
    logic [AW-1:0] waddr, main_raddr, side_raddr;
    logic [31:0]   wdata, main_rdata, gather_rdata, scatter_rdata;
    logic [LW-1:0] main_len, gather_len, scatter_len;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg   <= '0;
            source_base_reg   <= '0;
            target_base_reg   <= '0;
            gather_delta_reg  <= '0;
            scatter_delta_reg <= '0;
            wrap_count_reg    <= 32'd1;
            repeat_count_reg  <= 32'd1;
            access_bytes_reg  <= 7'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_KERNEL_MODE:   kernel_mode_reg   <= cfg_data[2:0];
                CFG_SOURCE_BASE:   source_base_reg   <= cfg_data;
                CFG_TARGET_BASE:   target_base_reg   <= cfg_data;
                CFG_GATHER_DELTA:  gather_delta_reg  <= cfg_data[31:0];
                CFG_SCATTER_DELTA: scatter_delta_reg <= cfg_data[31:0];
                CFG_WRAP_COUNT:    wrap_count_reg    <= cfg_data[31:0];
                CFG_REPEAT_COUNT:  repeat_count_reg  <= cfg_data[31:0];
                CFG_ACCESS_BYTES:  access_bytes_reg  <= cfg_data[6:0];
                default:           kernel_mode_reg   <= kernel_mode_reg;
            endcase
        end
    end

    gsag_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .back_idle   (back_idle),
        .pop         (pop),
        .busy        (busy),
        .step_valid  (step_valid),
        .we_main     (we_main),
        .we_gather   (we_gather),
        .we_scatter  (we_scatter),
        .waddr       (waddr),
        .wdata       (wdata),
        .main_len    (main_len),
        .gather_len  (gather_len),
        .scatter_len (scatter_len),
        .clear_run   (clear_run)
    );

    gsag_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_main_ram (
        .clk (clk), .we (we_main), .waddr (waddr), .wdata (wdata),
        .raddr (main_raddr), .rdata (main_rdata)
    );
    gsag_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_gather_ram (
        .clk (clk), .we (we_gather), .waddr (waddr), .wdata (wdata),
        .raddr (side_raddr), .rdata (gather_rdata)
    );
    gsag_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_scatter_ram (
        .clk (clk), .we (we_scatter), .waddr (waddr), .wdata (wdata),
        .raddr (side_raddr), .rdata (scatter_rdata)
    );

    gsag_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_valid    (step_valid),
        .clear_run     (clear_run),
        .main_len      (main_len),
        .gather_len    (gather_len),
        .scatter_len   (scatter_len),
        .kernel_mode   (kernel_mode_reg),
        .source_base   (source_base_reg),
        .target_base   (target_base_reg),
        .gather_delta  (gather_delta_reg),
        .scatter_delta (scatter_delta_reg),
        .wrap_count    (wrap_count_reg),
        .repeat_count  (repeat_count_reg),
        .access_bytes  (access_bytes_reg),
        .main_rdata    (main_rdata),
        .gather_rdata  (gather_rdata),
        .scatter_rdata (scatter_rdata),
        .main_raddr    (main_raddr),
        .side_raddr    (side_raddr),
        .pop           (pop),
        .idle          (back_idle),
        .result_valid  (result_valid),
        .result        (result)
    );

endmodule

/* rtl/gsag_ram.sv */
// Generic simple dual-port RAM with registered read.
module gsag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/gsag_divmod.sv */
// Iterative 32-bit remainder unit, one quotient bit per cycle.
module gsag_divmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    // One restoring step per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, div_reg};
        if (go)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
            end
            quo_next = {quo_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = busy_reg && (cnt_reg == 6'd1);
    assign remainder = trial[32] ? {rem_reg[30:0], quo_reg[31]} : trial[31:0];

endmodule

/* rtl/gsag_front.sv */
// Front end: accepts beats, writes the tables and keeps their lengths, queues step commands.
module gsag_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  gsag_pkg::in_item_t       item,
    input  logic                     back_idle,
    input  logic                     pop,
    output logic                     busy,
    output logic                     step_valid,
    output logic                     we_main,
    output logic                     we_gather,
    output logic                     we_scatter,
    output logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    output logic [31:0]              wdata,
    output logic [$clog2(TABLE_DEPTH):0] main_len,
    output logic [$clog2(TABLE_DEPTH):0] gather_len,
    output logic [$clog2(TABLE_DEPTH):0] scatter_len,
    output logic                     clear_run
);
    import gsag_pkg::*;

    localparam int LW = $clog2(TABLE_DEPTH) + 1;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [LW-1:0] FULL = LW'(TABLE_DEPTH);

    logic [LW-1:0] main_len_reg, gather_len_reg, scatter_len_reg;
    logic [1:0]    q_cnt_reg, q_cnt_next;
    logic          accept, push, is_clear, is_step;

    // Steps queue as a count; any other beat waits for the back end to drain,
    // so table contents and lengths never change under a queued step.
    assign is_clear = (op_t'(item.op) == OP_CLEAR);
    assign is_step  = (op_t'(item.op) == OP_STEP);
    assign busy   = (q_cnt_reg == 2'd2) || (!is_step && (!back_idle || q_cnt_reg != 2'd0));
    assign accept = start && !busy;
    assign push   = accept && is_step;
    assign clear_run = accept && is_clear;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        case ({push, pop})
            2'b10:   q_cnt_next = q_cnt_reg + 2'd1;
            2'b01:   q_cnt_next = q_cnt_reg - 2'd1;
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    // Table appends.
    always_comb
    begin
        we_main    = 1'b0;
        we_gather  = 1'b0;
        we_scatter = 1'b0;
        waddr      = '0;
        case (op_t'(item.op))
            OP_MAIN:
            begin
                we_main = accept && (main_len_reg != FULL);
                waddr   = main_len_reg[AW-1:0];
            end
            OP_GATHER:
            begin
                we_gather = accept && (gather_len_reg != FULL);
                waddr     = gather_len_reg[AW-1:0];
            end
            OP_SCATTER:
            begin
                we_scatter = accept && (scatter_len_reg != FULL);
                waddr      = scatter_len_reg[AW-1:0];
            end
            default: waddr = '0;
        endcase
    end
    assign wdata = item.entry_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_len_reg    <= '0;
            gather_len_reg  <= '0;
            scatter_len_reg <= '0;
            q_cnt_reg       <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (clear_run)
            begin
                main_len_reg    <= '0;
                gather_len_reg  <= '0;
                scatter_len_reg <= '0;
            end
            if (we_main)
            begin
                main_len_reg <= main_len_reg + LW'(1);
            end
            if (we_gather)
            begin
                gather_len_reg <= gather_len_reg + LW'(1);
            end
            if (we_scatter)
            begin
                scatter_len_reg <= scatter_len_reg + LW'(1);
            end
        end
    end

    assign step_valid  = (q_cnt_reg != 2'd0);
    assign main_len    = main_len_reg;
    assign gather_len  = gather_len_reg;
    assign scatter_len = scatter_len_reg;

endmodule

/* rtl/gsag_back.sv */
// Back end: runs one step at a time and emits the read and write beats.
module gsag_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step_valid,
    input  logic                     clear_run,
    input  logic [$clog2(TABLE_DEPTH):0] main_len,
    input  logic [$clog2(TABLE_DEPTH):0] gather_len,
    input  logic [$clog2(TABLE_DEPTH):0] scatter_len,
    input  logic [2:0]               kernel_mode,
    input  logic [47:0]              source_base,
    input  logic [47:0]              target_base,
    input  logic [31:0]              gather_delta,
    input  logic [31:0]              scatter_delta,
    input  logic [31:0]              wrap_count,
    input  logic [31:0]              repeat_count,
    input  logic [6:0]               access_bytes,
    input  logic [31:0]              main_rdata,
    input  logic [31:0]              gather_rdata,
    input  logic [31:0]              scatter_rdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] main_raddr,
    output logic [$clog2(TABLE_DEPTH)-1:0] side_raddr,
    output logic                     pop,
    output logic                     idle,
    output logic                     result_valid,
    output gsag_pkg::out_item_t      result
);
    import gsag_pkg::*;

    localparam int LW = $clog2(TABLE_DEPTH) + 1;
    localparam int AW = $clog2(TABLE_DEPTH);

    bk_state_t     state_reg, state_next;
    logic [AW-1:0] pos_reg;
    logic [31:0]   rep_reg;
    logic          fin_reg;
    logic [LW-1:0] plen_reg;
    logic [31:0]   ent_reg, gent_reg, sent_reg;
    logic          err_reg, done_reg;
    logic [63:0]   dprod_reg, sprod_reg, tprod_reg;
    logic [47:0]   rd_reg, wr_reg;
    logic [31:0]   modv;
    logic          mod_done, mod_go;
    logic [LW-1:0] plen_sel;
    logic          kvalid, start_step, is_multi;
    logic [31:0]   wrap_eff, reps_eff, idx;
    logic [31:0]   gent_now, sent_now, idx_now;
    logic          last_pos, last_rep;
    logic [47:0]   dense, srcg, srcs;

    // Pattern length for the selected kernel.
    always_comb
    begin
        kvalid   = 1'b1;
        plen_sel = main_len;
        case (kmode_t'(kernel_mode))
            KM_GATHER, KM_SCATTER:         plen_sel = main_len;
            KM_GS, KM_MULTISCATTER:        plen_sel = scatter_len;
            KM_MULTIGATHER:                plen_sel = gather_len;
            default:
            begin
                kvalid   = 1'b0;
                plen_sel = main_len;
            end
        endcase
    end

    assign wrap_eff   = (wrap_count == '0) ? 32'd1 : wrap_count;
    assign reps_eff   = (repeat_count == '0) ? 32'd1 : repeat_count;
    assign start_step = (state_reg == BK_IDLE) && step_valid;
    assign pop        = start_step;
    assign idle       = (state_reg == BK_IDLE);
    assign mod_go     = start_step;
    assign is_multi   = (kmode_t'(kernel_mode) == KM_MULTIGATHER) ||
                        (kmode_t'(kernel_mode) == KM_MULTISCATTER);

    gsag_divmod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .dividend  (rep_reg),
        .divisor   (wrap_eff),
        .done      (mod_done),
        .remainder (modv)
    );

    // Side table entries as they come out of the RAMs, zero beyond the length.
    assign gent_now = ({1'b0, pos_reg} < gather_len) ? gather_rdata : 32'd0;
    assign sent_now = ({1'b0, pos_reg} < scatter_len) ? scatter_rdata : 32'd0;

    // Indirect index from the side table, live while reading and registered after.
    assign idx_now = (kmode_t'(kernel_mode) == KM_MULTIGATHER) ? gent_now : sent_now;
    assign idx     = (kmode_t'(kernel_mode) == KM_MULTIGATHER) ? gent_reg : sent_reg;

    // Table read addresses; the indirect read is held while the remainder runs.
    always_comb
    begin
        side_raddr = pos_reg;
        main_raddr = pos_reg;
        if (is_multi && state_reg == BK_READ1)
        begin
            main_raddr = idx_now[AW-1:0];
        end
        else if (is_multi && state_reg == BK_READ2)
        begin
            main_raddr = idx[AW-1:0];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (start_step && !fin_reg && kvalid && plen_sel != '0)
                begin
                    state_next = BK_READ1;
                end
            end
            BK_READ1:   state_next = BK_READ2;
            BK_READ2:   state_next = mod_done ? BK_MUL : BK_READ2;
            BK_MUL:     state_next = BK_EMIT_RD;
            BK_EMIT_RD: state_next = BK_EMIT_WR;
            BK_EMIT_WR: state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    assign last_pos = ({{(33-AW){1'b0}}, pos_reg} + 33'd1) >= {{(33-LW){1'b0}}, plen_reg};
    assign last_rep = ({1'b0, rep_reg} + 33'd1) >= {1'b0, reps_eff};
    assign dense = target_base + tprod_reg[47:0];
    assign srcg  = source_base + {16'd0, ent_reg} + dprod_reg[47:0];
    assign srcs  = source_base + {16'd0, ent_reg} + sprod_reg[47:0];

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                plen_reg  <= plen_sel;
                dprod_reg <= {32'd0, gather_delta} * {32'd0, rep_reg};
                sprod_reg <= {32'd0, scatter_delta} * {32'd0, rep_reg};
            end
            BK_READ1:
            begin
                gent_reg <= gent_now;
                sent_reg <= sent_now;
                ent_reg  <= ({1'b0, pos_reg} < main_len) ? main_rdata : 32'd0;
            end
            BK_READ2:
            begin
                if (is_multi)
                begin
                    err_reg <= !(idx < {{(32-LW){1'b0}}, main_len});
                    ent_reg <= (idx < {{(32-LW){1'b0}}, main_len}) ? main_rdata : 32'd0;
                end
                else
                begin
                    err_reg <= 1'b0;
                end
                tprod_reg <= {{(64-LW){1'b0}}, plen_reg} * {32'd0, modv};
            end
            BK_MUL:
            begin
                case (kmode_t'(kernel_mode))
                    KM_SCATTER:
                    begin
                        rd_reg <= dense;
                        wr_reg <= srcg;
                    end
                    KM_GS:
                    begin
                        rd_reg <= source_base + {16'd0, gent_reg} + dprod_reg[47:0];
                        wr_reg <= target_base + {16'd0, sent_reg} + sprod_reg[47:0];
                    end
                    KM_MULTISCATTER:
                    begin
                        rd_reg <= dense;
                        wr_reg <= srcs;
                    end
                    default:
                    begin
                        rd_reg <= srcg;
                        wr_reg <= dense;
                    end
                endcase
                done_reg <= last_pos && last_rep;
            end
            default:
            begin
                rd_reg <= rd_reg;
            end
        endcase
    end

    // Run position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            pos_reg   <= '0;
            rep_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_run)
            begin
                pos_reg <= '0;
                rep_reg <= '0;
                fin_reg <= 1'b0;
            end
            else if (state_reg == BK_MUL)
            begin
                if (last_pos)
                begin
                    pos_reg <= '0;
                    if (last_rep)
                    begin
                        rep_reg <= '0;
                        fin_reg <= 1'b1;
                    end
                    else
                    begin
                        rep_reg <= rep_reg + 32'd1;
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + AW'(1);
                end
            end
        end
    end

    // Result beat outputs.
    always_comb
    begin
        result_valid       = (state_reg == BK_EMIT_RD) || (state_reg == BK_EMIT_WR);
        result.is_write    = (state_reg == BK_EMIT_WR);
        result.last        = (state_reg == BK_EMIT_WR);
        result.address     = (state_reg == BK_EMIT_WR) ? wr_reg : rd_reg;
        result.size_bytes  = access_bytes;
        result.run_done    = done_reg;
        result.index_error = err_reg;
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the gather/scatter address generator.
module testbench;
    import gsag_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 120;

    // One queued command beat with the idle cycles to leave in front of it.
    typedef struct {
        in_item_t cmd;
        int       gap;
        bit       hold_for_drain;
    } pending_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        result_valid;
    out_item_t   result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    pending_cmd_t cmd_queue[$];
    out_item_t    addr_queue[$];
    int           issued_cnt;
    int           accepted_cnt;
    int           error_cnt;
    int           cycle_cnt;
    int           counted_items;
    bit           no_gaps;

    // Shadow copy of the tables, the walk state and the registers.
    bit [31:0] main_tab[DEPTH];
    bit [31:0] gath_tab[DEPTH];
    bit [31:0] scat_tab[DEPTH];
    bit [31:0] main_len;
    bit [31:0] gath_len;
    bit [31:0] scat_len;
    bit [31:0] walk_pos;
    bit [31:0] walk_rep;
    bit        walk_finished;
    bit [2:0]  m_kernel;
    bit [47:0] m_source;
    bit [47:0] m_target;
    bit [31:0] m_gdelta;
    bit [31:0] m_sdelta;
    bit [31:0] m_wrap;
    bit [31:0] m_repeat;
    bit [6:0]  m_bytes;

    gather_scatter_address_generator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    // Table lookup that reads zero beyond the filled length.
    function automatic bit [31:0] table_entry(input int which, input bit [63:0] pos);
        bit [31:0] len;
        begin
            len = (which == 0) ? main_len : (which == 1) ? gath_len : scat_len;
            if (pos >= len || pos >= DEPTH)
                return 32'd0;
            if (which == 0)
                return main_tab[pos];
            if (which == 1)
                return gath_tab[pos];
            return scat_tab[pos];
        end
    endfunction

    function automatic void push_access(input bit [63:0] addr, input bit wr, input bit done,
                                        input bit err);
        out_item_t o;
        begin
            o.address     = addr[47:0];
            o.is_write    = wr;
            o.size_bytes  = m_bytes;
            o.last        = wr;
            o.run_done    = done;
            o.index_error = err;
            addr_queue = {addr_queue, o};
        end
    endfunction

    // Apply one accepted command to the shadow state and queue its address pair.
    function automatic void predict_addresses(input in_item_t c);
        bit [31:0] plen;
        bit [31:0] wrap;
        bit [31:0] reps;
        bit [31:0] ent;
        bit [31:0] idx;
        bit [63:0] rd;
        bit [63:0] wr;
        bit [63:0] dense;
        bit        err;
        bit        done;
        begin
            err  = 1'b0;
            done = 1'b0;
            case (c.op)
                OP_CLEAR:
                begin
                    main_len = 0;
                    gath_len = 0;
                    scat_len = 0;
                    walk_pos = 0;
                    walk_rep = 0;
                    walk_finished = 1'b0;
                    return;
                end
                OP_MAIN:
                begin
                    if (main_len < DEPTH)
                    begin
                        main_tab[main_len] = c.entry_value;
                        main_len++;
                    end
                    return;
                end
                OP_GATHER:
                begin
                    if (gath_len < DEPTH)
                    begin
                        gath_tab[gath_len] = c.entry_value;
                        gath_len++;
                    end
                    return;
                end
                OP_SCATTER:
                begin
                    if (scat_len < DEPTH)
                    begin
                        scat_tab[scat_len] = c.entry_value;
                        scat_len++;
                    end
                    return;
                end
                OP_STEP: ;
                default: return;
            endcase
            if (walk_finished)
                return;
            case (m_kernel)
                KM_GATHER, KM_SCATTER:     plen = main_len;
                KM_GS, KM_MULTISCATTER:    plen = scat_len;
                KM_MULTIGATHER:            plen = gath_len;
                default:                   return;
            endcase
            if (plen == 0)
                return;
            wrap  = (m_wrap == 0) ? 32'd1 : m_wrap;
            reps  = (m_repeat == 0) ? 32'd1 : m_repeat;
            dense = 64'(m_target) + 64'(plen) * 64'(walk_rep % wrap);
            case (m_kernel)
                KM_GATHER:
                begin
                    ent = table_entry(0, walk_pos);
                    rd  = 64'(m_source) + 64'(ent) + 64'(m_gdelta) * 64'(walk_rep);
                    wr  = dense;
                end
                KM_SCATTER:
                begin
                    ent = table_entry(0, walk_pos);
                    rd  = dense;
                    wr  = 64'(m_source) + 64'(ent) + 64'(m_gdelta) * 64'(walk_rep);
                end
                KM_GS:
                begin
                    rd = 64'(m_source) + 64'(table_entry(1, walk_pos))
                         + 64'(m_gdelta) * 64'(walk_rep);
                    wr = 64'(m_target) + 64'(table_entry(2, walk_pos))
                         + 64'(m_sdelta) * 64'(walk_rep);
                end
                KM_MULTIGATHER:
                begin
                    idx = table_entry(1, walk_pos);
                    err = (idx >= main_len);
                    ent = table_entry(0, idx);
                    rd  = 64'(m_source) + 64'(ent) + 64'(m_gdelta) * 64'(walk_rep);
                    wr  = dense;
                end
                default:
                begin
                    idx = table_entry(2, walk_pos);
                    err = (idx >= main_len);
                    ent = table_entry(0, idx);
                    rd  = dense;
                    wr  = 64'(m_source) + 64'(ent) + 64'(m_sdelta) * 64'(walk_rep);
                end
            endcase
            // Advance the pattern position, then the repetition at the pattern end.
            if (64'(walk_pos) + 1 >= 64'(plen))
            begin
                walk_pos = 0;
                if (64'(walk_rep) + 1 >= 64'(reps))
                begin
                    walk_rep = 0;
                    walk_finished = 1'b1;
                    done = 1'b1;
                end
                else
                    walk_rep++;
            end
            else
                walk_pos++;
            push_access(rd, 1'b0, done, err);
            push_access(wr, 1'b1, done, err);
        end
    endfunction

    // Command driver: takes beats from the pending queue, honoring gaps and drain holds.
    always @(posedge clk or negedge rst_n)
    begin
        logic     nxt_start;
        in_item_t nxt_item;
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            nxt_start = start;
            nxt_item  = item;
            if (start && !busy)
            begin
                predict_addresses(item);
                accepted_cnt++;
                nxt_start = 1'b0;
            end
            if (!nxt_start && cmd_queue.size() > 0)
            begin
                if (cmd_queue[0].gap > 0)
                    cmd_queue[0].gap--;
                else if (!(cmd_queue[0].hold_for_drain && addr_queue.size() != 0))
                begin
                    nxt_item  = cmd_queue[0].cmd;
                    nxt_start = 1'b1;
                    void'(cmd_queue.pop_front());
                    issued_cnt++;
                end
            end
            start <= nxt_start;
            item  <= nxt_item;
        end
    end

    // Result monitor: every strobed beat must match the oldest expected address.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid)
        begin
            if (addr_queue.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, result);
                error_cnt++;
            end
            else
            begin
                want = addr_queue.pop_front();
                if (result.address !== want.address)
                begin
                    $display("%0t: address expected %h actual %h", $time, want.address,
                             result.address);
                    error_cnt++;
                end
                if (result.is_write !== want.is_write)
                begin
                    $display("%0t: is_write expected %b actual %b", $time, want.is_write,
                             result.is_write);
                    error_cnt++;
                end
                if (result.size_bytes !== want.size_bytes)
                begin
                    $display("%0t: size_bytes expected %0d actual %0d", $time,
                             want.size_bytes, result.size_bytes);
                    error_cnt++;
                end
                if (result.last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, result.last);
                    error_cnt++;
                end
                if (result.run_done !== want.run_done)
                begin
                    $display("%0t: run_done expected %b actual %b", $time, want.run_done,
                             result.run_done);
                    error_cnt++;
                end
                if (result.index_error !== want.index_error)
                begin
                    $display("%0t: index_error expected %b actual %b", $time,
                             want.index_error, result.index_error);
                    error_cnt++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        begin
            if (no_gaps)
                return 0;
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(10, 60);
        end
    endfunction

    function automatic void queue_cmd(input op_t op, input bit [31:0] val,
                                      input bit drain = 1'b0);
        pending_cmd_t p;
        begin
            p.cmd.op          = op;
            p.cmd.entry_value = val;
            p.gap             = pick_gap();
            p.hold_for_drain  = drain;
            cmd_queue = {cmd_queue, p};
            counted_items++;
        end
    endfunction

    // Unused opcodes, which the block ignores.
    function automatic void queue_noise();
        pending_cmd_t p;
        begin
            p.cmd.op          = 3'($urandom_range(5, 7));
            p.cmd.entry_value = $urandom;
            p.gap             = pick_gap();
            p.hold_for_drain  = 1'b0;
            cmd_queue = {cmd_queue, p};
        end
    endfunction

    // Register write beat, mirrored into the shadow registers.
    task automatic write_reg(input cfg_idx_t idx, input bit [47:0] val);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            case (idx)
                CFG_KERNEL_MODE:   m_kernel = val[2:0];
                CFG_SOURCE_BASE:   m_source = val;
                CFG_TARGET_BASE:   m_target = val;
                CFG_GATHER_DELTA:  m_gdelta = val[31:0];
                CFG_SCATTER_DELTA: m_sdelta = val[31:0];
                CFG_WRAP_COUNT:    m_wrap   = val[31:0];
                CFG_REPEAT_COUNT:  m_repeat = val[31:0];
                default:           m_bytes  = val[6:0];
            endcase
        end
    endtask

    task automatic end_writes();
        begin
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Wait until every command is taken and every address pair has come out.
    task automatic wait_idle();
        begin
            while (!(cmd_queue.size() == 0 && accepted_cnt == issued_cnt &&
                     addr_queue.size() == 0))
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    function automatic bit [47:0] pick_wide(input int bits);
        int r;
        bit [63:0] v;
        begin
            r = $urandom_range(0, 9);
            v = {$urandom, $urandom};
            if (r == 0)
                return 48'd0;
            if (r == 1)
                return 48'((64'd1 << bits) - 1);
            if (r < 5)
                return 48'($urandom_range(0, 4096));
            return 48'(v & ((64'd1 << bits) - 1));
        end
    endfunction

    // A random run: registers, then a clear, table fills and a burst of steps.
    task automatic random_run();
        int        n_main;
        int        n_gath;
        int        n_scat;
        int        n_steps;
        int        r;
        bit [31:0] rc;
        bit [31:0] wc;
        begin
            r = $urandom_range(0, 19);
            write_reg(CFG_KERNEL_MODE, (r == 0) ? 48'($urandom_range(5, 7))
                                                : 48'($urandom_range(0, 4)));
            write_reg(CFG_SOURCE_BASE, pick_wide(48));
            write_reg(CFG_TARGET_BASE, pick_wide(48));
            write_reg(CFG_GATHER_DELTA, pick_wide(32));
            write_reg(CFG_SCATTER_DELTA, pick_wide(32));
            r  = $urandom_range(0, 9);
            wc = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 5));
            write_reg(CFG_WRAP_COUNT, 48'(wc));
            r  = $urandom_range(0, 14);
            rc = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 5));
            write_reg(CFG_REPEAT_COUNT, 48'(rc));
            write_reg(CFG_ACCESS_BYTES, 48'($urandom_range(0, 127)));
            end_writes();
            no_gaps = ($urandom_range(0, 3) == 0);

            n_main = $urandom_range(0, 6);
            n_gath = $urandom_range(0, 6);
            n_scat = $urandom_range(0, 6);
            queue_cmd(OP_CLEAR, $urandom);
            for (int i = 0; i < n_main; i++)
                queue_cmd(OP_MAIN, $urandom);
            // Indirect indices mostly fall inside the main table or just past its end.
            for (int i = 0; i < n_gath; i++)
                queue_cmd(OP_GATHER, ($urandom_range(0, 5) == 0) ? $urandom
                                     : 32'($urandom_range(0, n_main + 1)));
            for (int i = 0; i < n_scat; i++)
                queue_cmd(OP_SCATTER, ($urandom_range(0, 5) == 0) ? $urandom
                                      : 32'($urandom_range(0, n_main + 1)));
            n_steps = $urandom_range(4, 24);
            for (int i = 0; i < n_steps; i++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    queue_noise();
                else if (r == 1)
                    queue_cmd(op_t'($urandom_range(1, 3)), $urandom);
                queue_cmd(OP_STEP, $urandom, (i == n_steps / 2) && ($urandom_range(0, 2) == 0));
            end
            wait_idle();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        issued_cnt = 0;
        accepted_cnt = 0;
        error_cnt = 0;
        cycle_cnt = 0;
        counted_items = 0;
        no_gaps = 1'b0;
        main_len = 0;
        gath_len = 0;
        scat_len = 0;
        walk_pos = 0;
        walk_rep = 0;
        walk_finished = 1'b0;
        m_kernel = KM_GATHER;
        m_source = 0;
        m_target = 0;
        m_gdelta = 0;
        m_sdelta = 0;
        m_wrap = 1;
        m_repeat = 1;
        m_bytes = 8;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: empty pattern, unused ops, extreme entries, end of run.
        queue_cmd(OP_STEP, 32'd0);
        queue_noise();
        queue_cmd(OP_MAIN, 32'd0);
        queue_cmd(OP_MAIN, 32'hFFFF_FFFF);
        queue_cmd(OP_STEP, 32'hFFFF_FFFF);
        queue_cmd(OP_STEP, 32'd0);
        queue_cmd(OP_STEP, 32'd0);
        wait_idle();

        // Gather-scatter at extreme bases and deltas, gather table shorter than scatter.
        write_reg(CFG_KERNEL_MODE, KM_GS);
        write_reg(CFG_SOURCE_BASE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_TARGET_BASE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_GATHER_DELTA, 48'hFFFF_FFFF);
        write_reg(CFG_SCATTER_DELTA, 48'hFFFF_FFFF);
        write_reg(CFG_WRAP_COUNT, 48'd0);
        write_reg(CFG_REPEAT_COUNT, 48'd2);
        write_reg(CFG_ACCESS_BYTES, 48'd127);
        end_writes();
        queue_cmd(OP_CLEAR, 32'd0);
        queue_cmd(OP_GATHER, 32'hFFFF_FFFF);
        queue_cmd(OP_SCATTER, 32'h8000_0000);
        queue_cmd(OP_SCATTER, 32'd1);
        for (int i = 0; i < 4; i++)
            queue_cmd(OP_STEP, 32'd0);
        wait_idle();

        // Multigather then multiscatter with an out-of-range indirect index.
        write_reg(CFG_KERNEL_MODE, KM_MULTIGATHER);
        write_reg(CFG_WRAP_COUNT, 48'hFFFF_FFFF);
        write_reg(CFG_REPEAT_COUNT, 48'd0);
        write_reg(CFG_ACCESS_BYTES, 48'd0);
        end_writes();
        queue_cmd(OP_CLEAR, 32'd0);
        queue_cmd(OP_MAIN, 32'h1234_5678);
        queue_cmd(OP_GATHER, 32'd0);
        queue_cmd(OP_GATHER, 32'd7);
        queue_cmd(OP_STEP, 32'd0);
        queue_cmd(OP_STEP, 32'd0);
        wait_idle();
        write_reg(CFG_KERNEL_MODE, KM_MULTISCATTER);
        end_writes();
        queue_cmd(OP_CLEAR, 32'd0);
        queue_cmd(OP_SCATTER, 32'hFFFF_FFFF);
        queue_cmd(OP_STEP, 32'd0);
        wait_idle();

        // Full main table: the append past the depth is dropped.
        write_reg(CFG_KERNEL_MODE, KM_SCATTER);
        write_reg(CFG_REPEAT_COUNT, 48'd1);
        end_writes();
        no_gaps = 1'b1;
        queue_cmd(OP_CLEAR, 32'd0);
        for (int i = 0; i <= DEPTH; i++)
            queue_cmd(OP_MAIN, $urandom);
        for (int i = 0; i < 4; i++)
            queue_cmd(OP_STEP, 32'd0);
        wait_idle();

        // Random runs over the remaining item budget.
        counted_items = 0;
        while (counted_items < 850)
            random_run();

        if (error_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* gather_scatter_address_generator.f */
rtl/gsag_pkg.sv
rtl/gsag_ram.sv
rtl/gsag_divmod.sv
rtl/gsag_front.sv
rtl/gsag_back.sv
rtl/gather_scatter_address_generator.sv
tb/testbench.sv
